>>> design/dns_query_builder_unit_defines.svh
// ----------------------------------------------------------------------------
// DNS query builder assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef DNS_QUERY_BUILDER_UNIT_DEFINES_SVH
`define DNS_QUERY_BUILDER_UNIT_DEFINES_SVH

// Same-cycle implication, off during reset.
`define DQB_CHK_IMP(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, also checked across reset.
`define DQB_CHK_NXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) (cond) |=> (prop)) else $error(msg);

`endif

>>> design/dqb_pkg.sv
// ----------------------------------------------------------------------------
// DNS query builder package
// Shared constants, command types and sequencer states.
// ----------------------------------------------------------------------------
package dqb_pkg;

  localparam int LABEL_MAX = 32;
  localparam int LEN_W = $clog2(LABEL_MAX + 1);
  localparam int IDX_W = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;

  localparam int CMD_FIFO_DEPTH = 2;
  localparam int CMD_FIFO_AW = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;

  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_QUERY_ID = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_FLAGS = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_QUERY_TYPE = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_QUERY_CLASS = 8'd3;

  localparam logic [15:0] QUERY_ID_RST = 16'h9bce;
  localparam logic [15:0] HEADER_FLAGS_RST = 16'h0100;
  localparam logic [15:0] QUERY_TYPE_RST = 16'h0001;
  localparam logic [15:0] QUERY_CLASS_RST = 16'h0001;

  localparam logic [7:0] DOT_CHAR = 8'h2e;
  localparam logic [7:0] QDCOUNT_LO = 8'h01;
  localparam logic [3:0] HDR_LAST = 4'd11;
  localparam logic [3:0] TAIL_LAST = 4'd3;

  typedef enum logic [1:0] {
    CMD_CHAR,
    CMD_DOT,
    CMD_END
  } cmd_kind_t;

  typedef struct packed {
    logic      hdr;
    cmd_kind_t kind;
    logic [7:0] ch;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HDR,
    ST_EXEC,
    ST_LEN,
    ST_LBL,
    ST_ROOT,
    ST_TAIL
  } back_state_t;

endpackage

>>> design/dqb_name_if.sv
// ----------------------------------------------------------------------------
// Host name channel
// One name character or end marker per request.
// ----------------------------------------------------------------------------
interface dqb_name_if;
  logic       valid;
  logic       ready;
  logic [7:0] name_char;
  logic       end_of_name;

  modport source(output valid, output name_char, output end_of_name, input ready);
  modport sink(input valid, input name_char, input end_of_name, output ready);
endinterface

>>> design/dqb_msg_if.sv
// ----------------------------------------------------------------------------
// Query message channel
// One message byte with its markers per request.
// ----------------------------------------------------------------------------
interface dqb_msg_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;
  logic       label_too_long;

  modport source(output valid, output out_byte, output last_byte,
                 output label_too_long, input ready);
  modport sink(input valid, input out_byte, input last_byte,
               input label_too_long, output ready);
endinterface

>>> design/dqb_front.sv
// ----------------------------------------------------------------------------
// DNS query builder front end
// Accepts name requests, classifies them and tags the first of each name.
// ----------------------------------------------------------------------------
module dqb_front (
  input  logic           clk,
  input  logic           rst,
  dqb_name_if.sink       name_chan,
  input  logic           fifo_full,
  output logic           push,
  output dqb_pkg::cmd_t  cmd
);

  logic started;

  assign name_chan.ready = !fifo_full;
  assign push = name_chan.valid && !fifo_full;

  always_comb begin
    cmd.hdr = !started;
    cmd.ch = name_chan.name_char;
    if (name_chan.end_of_name) begin
      cmd.kind = dqb_pkg::CMD_END;
    end else if (name_chan.name_char == dqb_pkg::DOT_CHAR) begin
      cmd.kind = dqb_pkg::CMD_DOT;
    end else begin
      cmd.kind = dqb_pkg::CMD_CHAR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
    end else if (push) begin
      started <= !name_chan.end_of_name;
    end
  end

endmodule

>>> design/dqb_cmd_fifo.sv
// ----------------------------------------------------------------------------
// DNS query builder command queue
// Short queue between the front end and the byte sequencer.
// ----------------------------------------------------------------------------
module dqb_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  dqb_pkg::cmd_t  push_data,
  output logic           full,
  input  logic           pop,
  output dqb_pkg::cmd_t  pop_data,
  output logic           not_empty
);

  dqb_pkg::cmd_t                  slots [dqb_pkg::CMD_FIFO_DEPTH];
  logic [dqb_pkg::CMD_FIFO_AW-1:0] wr_ptr;
  logic [dqb_pkg::CMD_FIFO_AW-1:0] rd_ptr;
  logic [dqb_pkg::CMD_FIFO_AW:0]   count;
  logic                           do_push;
  logic                           do_pop;

  assign full = (count == (dqb_pkg::CMD_FIFO_AW + 1)'(dqb_pkg::CMD_FIFO_DEPTH));
  assign not_empty = (count != '0);
  assign do_push = push && !full;
  assign do_pop = pop && not_empty;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        if (wr_ptr == dqb_pkg::CMD_FIFO_AW'(dqb_pkg::CMD_FIFO_DEPTH - 1)) begin
          wr_ptr <= '0;
        end else begin
          wr_ptr <= wr_ptr + 1'b1;
        end
      end
      if (do_pop) begin
        if (rd_ptr == dqb_pkg::CMD_FIFO_AW'(dqb_pkg::CMD_FIFO_DEPTH - 1)) begin
          rd_ptr <= '0;
        end else begin
          rd_ptr <= rd_ptr + 1'b1;
        end
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> design/dqb_back.sv
// ----------------------------------------------------------------------------
// DNS query builder back end
// Byte sequencer: header, label flush, root and trailer, label store.
// ----------------------------------------------------------------------------
module dqb_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [dqb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dqb_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              cmd_valid,
  input  dqb_pkg::cmd_t                     cmd,
  output logic                              pop,
  dqb_msg_if.source                         msg_chan
);

  dqb_pkg::back_state_t       state;
  dqb_pkg::back_state_t       state_next;
  dqb_pkg::cmd_t              cur;
  dqb_pkg::cmd_t              cur_next;
  logic [3:0]                 cnt;
  logic [3:0]                 cnt_next;
  logic [dqb_pkg::LEN_W-1:0]  idx;
  logic [dqb_pkg::LEN_W-1:0]  idx_next;
  logic [dqb_pkg::LEN_W-1:0]  idx_inc;
  logic [dqb_pkg::LEN_W-1:0]  label_length;
  logic [dqb_pkg::LEN_W-1:0]  label_length_next;
  logic                       label_overflow;
  logic                       label_overflow_next;
  logic [7:0]                 label_store [dqb_pkg::LABEL_MAX];
  logic [7:0]                 rd_data;
  logic                       wr_en;

  logic [15:0] query_id;
  logic [15:0] header_flags;
  logic [15:0] query_type;
  logic [15:0] query_class;

  logic       out_free;
  logic       emit;
  logic [7:0] e_byte;
  logic       e_last;
  logic       e_flag;
  logic [7:0] hdr_byte;
  logic [7:0] tail_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      query_id <= dqb_pkg::QUERY_ID_RST;
      header_flags <= dqb_pkg::HEADER_FLAGS_RST;
      query_type <= dqb_pkg::QUERY_TYPE_RST;
      query_class <= dqb_pkg::QUERY_CLASS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        dqb_pkg::REG_QUERY_ID: query_id <= cfg_data[15:0];
        dqb_pkg::REG_HEADER_FLAGS: header_flags <= cfg_data[15:0];
        dqb_pkg::REG_QUERY_TYPE: query_type <= cfg_data[15:0];
        dqb_pkg::REG_QUERY_CLASS: query_class <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cnt)
      4'd0: hdr_byte = query_id[15:8];
      4'd1: hdr_byte = query_id[7:0];
      4'd2: hdr_byte = header_flags[15:8];
      4'd3: hdr_byte = header_flags[7:0];
      4'd5: hdr_byte = dqb_pkg::QDCOUNT_LO;
      default: hdr_byte = 8'h00;
    endcase
    case (cnt[1:0])
      2'd0: tail_byte = query_type[15:8];
      2'd1: tail_byte = query_type[7:0];
      2'd2: tail_byte = query_class[15:8];
      default: tail_byte = query_class[7:0];
    endcase
  end

  assign out_free = !msg_chan.valid || msg_chan.ready;
  assign idx_inc = idx + 1'b1;

  always_comb begin
    state_next = state;
    cur_next = cur;
    cnt_next = cnt;
    idx_next = idx;
    label_length_next = label_length;
    label_overflow_next = label_overflow;
    wr_en = 1'b0;
    pop = 1'b0;
    emit = 1'b0;
    e_byte = 8'h00;
    e_last = 1'b0;
    e_flag = 1'b0;
    case (state)
      dqb_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          pop = 1'b1;
          cur_next = cmd;
          cnt_next = '0;
          state_next = cmd.hdr ? dqb_pkg::ST_HDR : dqb_pkg::ST_EXEC;
        end
      end
      dqb_pkg::ST_HDR: begin
        e_byte = hdr_byte;
        if (out_free) begin
          emit = 1'b1;
          if (cnt == dqb_pkg::HDR_LAST) begin
            cnt_next = '0;
            state_next = dqb_pkg::ST_EXEC;
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end
      end
      dqb_pkg::ST_EXEC: begin
        idx_next = '0;
        case (cur.kind)
          dqb_pkg::CMD_CHAR: begin
            if (label_length < dqb_pkg::LEN_W'(dqb_pkg::LABEL_MAX)) begin
              wr_en = 1'b1;
              label_length_next = label_length + 1'b1;
            end else begin
              label_overflow_next = 1'b1;
            end
            state_next = dqb_pkg::ST_IDLE;
          end
          dqb_pkg::CMD_DOT: begin
            if (label_length == '0) begin
              label_overflow_next = 1'b0;
              state_next = dqb_pkg::ST_IDLE;
            end else begin
              state_next = dqb_pkg::ST_LEN;
            end
          end
          dqb_pkg::CMD_END: begin
            if (label_length == '0) begin
              label_overflow_next = 1'b0;
              state_next = dqb_pkg::ST_ROOT;
            end else begin
              state_next = dqb_pkg::ST_LEN;
            end
          end
          default: state_next = dqb_pkg::ST_IDLE;
        endcase
      end
      dqb_pkg::ST_LEN: begin
        idx_next = '0;
        e_byte = {{(8 - dqb_pkg::LEN_W){1'b0}}, label_length};
        e_flag = label_overflow;
        if (out_free) begin
          emit = 1'b1;
          state_next = dqb_pkg::ST_LBL;
        end
      end
      dqb_pkg::ST_LBL: begin
        e_byte = rd_data;
        if (out_free) begin
          emit = 1'b1;
          if (idx_inc == label_length) begin
            idx_next = '0;
            label_length_next = '0;
            label_overflow_next = 1'b0;
            state_next = (cur.kind == dqb_pkg::CMD_END) ? dqb_pkg::ST_ROOT
                                                         : dqb_pkg::ST_IDLE;
          end else begin
            idx_next = idx_inc;
          end
        end
      end
      dqb_pkg::ST_ROOT: begin
        if (out_free) begin
          emit = 1'b1;
          cnt_next = '0;
          state_next = dqb_pkg::ST_TAIL;
        end
      end
      dqb_pkg::ST_TAIL: begin
        e_byte = tail_byte;
        e_last = (cnt == dqb_pkg::TAIL_LAST);
        if (out_free) begin
          emit = 1'b1;
          if (cnt == dqb_pkg::TAIL_LAST) begin
            cnt_next = '0;
            state_next = dqb_pkg::ST_IDLE;
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end
      end
      default: state_next = dqb_pkg::ST_IDLE;
    endcase
  end

  // rd_data holds the entry at idx; right after a write to that entry it still shows the old value
  always_ff @(posedge clk) begin
    if (wr_en) begin
      label_store[label_length[dqb_pkg::IDX_W-1:0]] <= cur.ch;
    end
    rd_data <= label_store[idx_next[dqb_pkg::IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    if (rst) begin
      state <= dqb_pkg::ST_IDLE;
      cnt <= '0;
      idx <= '0;
      label_length <= '0;
      label_overflow <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      idx <= idx_next;
      label_length <= label_length_next;
      label_overflow <= label_overflow_next;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      msg_chan.out_byte <= e_byte;
      msg_chan.last_byte <= e_last;
      msg_chan.label_too_long <= e_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      msg_chan.valid <= 1'b0;
    end else if (emit) begin
      msg_chan.valid <= 1'b1;
    end else if (msg_chan.ready) begin
      msg_chan.valid <= 1'b0;
    end
  end

endmodule

>>> design/dns_query_builder_unit.sv
// Path: a first name request is queued, dequeued in the idle state and its header bytes
// are emitted from the header state via the registered output. Throughput: each request
// passes the sequencer's dequeue and execute states; message bytes leave at 1 per cycle
// while the receiver accepts them: 12 header bytes, 1 + length per flushed label, 5 closing bytes.
// Reset: synchronous rst clears control state and loads register defaults;
// the label store is not cleared and needs no startup pass.
// ----------------------------------------------------------------------------
// DNS query builder top level
// Front end, command queue and byte sequencer for DNS query messages.
// ----------------------------------------------------------------------------
module dns_query_builder_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [dqb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dqb_pkg::CFG_DATA_W-1:0]  cfg_data,
  dqb_name_if.sink                        name_chan,
  dqb_msg_if.source                       msg_chan
);

  logic          push;
  logic          fifo_full;
  logic          pop;
  logic          cmd_valid;
  dqb_pkg::cmd_t push_cmd;
  dqb_pkg::cmd_t pop_cmd;

  dqb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .name_chan (name_chan),
    .fifo_full (fifo_full),
    .push      (push),
    .cmd       (push_cmd)
  );

  dqb_cmd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_cmd),
    .full      (fifo_full),
    .pop       (pop),
    .pop_data  (pop_cmd),
    .not_empty (cmd_valid)
  );

  dqb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd       (pop_cmd),
    .pop       (pop),
    .msg_chan  (msg_chan)
  );

endmodule

>>> design/dqb_checker.sv
// ----------------------------------------------------------------------------
// DNS query builder port checker
// Port-level properties of the query builder, bound to the top level.
// ----------------------------------------------------------------------------
`include "dns_query_builder_unit_defines.svh"

module dqb_checker (
  input logic       clk,
  input logic       rst,
  input logic       name_ready,
  input logic       msg_valid,
  input logic       msg_ready,
  input logic [7:0] out_byte,
  input logic       last_byte,
  input logic       label_too_long
);

  `DQB_CHK_NXT(a_rst_no_out, rst, !msg_valid, "output request after reset")
  `DQB_CHK_NXT(a_rst_ready, rst, name_ready, "input not ready after reset")
  `DQB_CHK_NXT(a_out_hold, !rst && msg_valid && !msg_ready,
               msg_valid && $stable(out_byte) && $stable(last_byte) &&
               $stable(label_too_long), "stalled output request changed")
  `DQB_CHK_IMP(a_trunc_len, msg_valid && label_too_long,
               (out_byte == 8'(dqb_pkg::LABEL_MAX)) && !last_byte,
               "truncated label length byte wrong")

endmodule

bind dns_query_builder_unit dqb_checker u_dqb_checker (
  .clk            (clk),
  .rst            (rst),
  .name_ready     (name_chan.ready),
  .msg_valid      (msg_chan.valid),
  .msg_ready      (msg_chan.ready),
  .out_byte       (msg_chan.out_byte),
  .last_byte      (msg_chan.last_byte),
  .label_too_long (msg_chan.label_too_long)
);
